/* hdl/llcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llcp_pkg
// Shared constants for the closest-points-between-lines pipeline.
// ----------------------------------------------------------------------------
package llcp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // digit width of the pipelined multipliers
  localparam int DIGIT_W = 8;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int DIR_LIMIT_W = 16;
  localparam int DEN_LIMIT_W = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION_LIMIT   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_DENOMINATOR_LIMIT = CFG_INDEX_W'(1);

  localparam logic [DIR_LIMIT_W-1:0] DIR_LIMIT_RESET = DIR_LIMIT_W'(1);
  localparam logic [DEN_LIMIT_W-1:0] DEN_LIMIT_RESET = DEN_LIMIT_W'(1);

endpackage
`default_nettype wire

/* hdl/llcp_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llcp_mul
// Pipelined signed multiplier: one DIGIT_W-bit digit of |b| per stage,
// sign applied at the end. A tag travels alongside the product.
// ----------------------------------------------------------------------------
module llcp_mul #(
  parameter int AW = 33,
  parameter int BW = 33,
  parameter int TW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  input  logic [TW-1:0]        in_tag,
  output logic                 out_valid,
  output logic signed [AW+BW-1:0] p,
  output logic [TW-1:0]        out_tag
);

  localparam int DW = llcp_pkg::DIGIT_W;
  localparam int ND = (BW + DW - 1) / DW;
  localparam int MW = ND * DW;
  localparam int PW = AW + BW;

  logic          vld [0:ND];
  logic [TW-1:0] tag [0:ND];
  logic [AW-1:0] ma  [0:ND];
  logic [MW-1:0] mb  [0:ND];
  logic          neg [0:ND];
  logic [PW-1:0] acc [0:ND];

  logic [AW-1:0] a_abs;
  logic [BW-1:0] b_abs;

  always_comb begin
    a_abs = a[AW-1] ? AW'(-a) : AW'(a);
    b_abs = b[BW-1] ? BW'(-b) : BW'(b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= in_tag;
      ma[0]  <= a_abs;
      mb[0]  <= MW'(b_abs);
      neg[0] <= a[AW-1] ^ b[BW-1];
      acc[0] <= '0;
    end
  end

  for (genvar k = 1; k <= ND; k++) begin : g_stage
    logic [AW+DW-1:0] pp;

    always_comb begin
      pp = {{DW{1'b0}}, ma[k-1]} * {{AW{1'b0}}, mb[k-1][(k-1)*DW +: DW]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[k] <= tag[k-1];
        ma[k]  <= ma[k-1];
        mb[k]  <= mb[k-1];
        neg[k] <= neg[k-1];
        acc[k] <= acc[k-1] + (PW'(pp) << ((k-1) * DW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= tag[ND];
      p       <= neg[ND] ? -$signed(acc[ND]) : $signed(acc[ND]);
    end
  end

endmodule
`default_nettype wire

/* hdl/llcp_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llcp_div
// Pipelined restoring divider, one quotient bit per stage, quotient
// truncated toward zero. A tag travels alongside the quotient.
// ----------------------------------------------------------------------------
module llcp_div #(
  parameter int NW = 64,
  parameter int VW = 32,
  parameter int TW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] n,
  input  logic signed [VW-1:0] d,
  input  logic [TW-1:0]        in_tag,
  output logic                 out_valid,
  output logic signed [NW:0]   q,
  output logic [TW-1:0]        out_tag
);

  logic          vld [0:NW];
  logic [TW-1:0] tag [0:NW];
  logic [NW-1:0] xq  [0:NW];   // dividend shifts out as quotient shifts in
  logic [VW-1:0] rem [0:NW];
  logic [VW-1:0] y   [0:NW];
  logic          neg [0:NW];

  logic [NW-1:0] n_abs;
  logic [VW-1:0] d_abs;

  always_comb begin
    n_abs = n[NW-1] ? NW'(-n) : NW'(n);
    d_abs = d[VW-1] ? VW'(-d) : VW'(d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= in_tag;
      xq[0]  <= n_abs;
      rem[0] <= '0;
      y[0]   <= d_abs;
      neg[0] <= n[NW-1] ^ d[VW-1];
    end
  end

  for (genvar i = 1; i <= NW; i++) begin : g_stage
    logic [VW:0]   sh;
    logic [VW+1:0] df;
    logic          take;

    always_comb begin
      sh   = {rem[i-1], xq[i-1][NW-1]};
      df   = {1'b0, sh} - {2'b00, y[i-1]};
      take = ~df[VW+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[i] <= tag[i-1];
        xq[i]  <= {xq[i-1][NW-2:0], take};
        rem[i] <= take ? df[VW-1:0] : sh[VW-1:0];
        y[i]   <= y[i-1];
        neg[i] <= neg[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= tag[NW];
      q       <= neg[NW] ? -$signed({1'b0, xq[NW]}) : $signed({1'b0, xq[NW]});
    end
  end

endmodule
`default_nettype wire

/* hdl/line_line_closest_points.sv */
`timescale 1ns / 1ps
`default_nettype none
// Depth: set mostly by the two bit-per-stage dividers at the default widths
//   (153 and 223 stages).
// Throughput: one item per cycle; the whole pipeline stalls together when the
//   output register is full and not taken.
// Reset: synchronous, clears all valid bits and loads both limits with 1.
// ----------------------------------------------------------------------------
// line_line_closest_points
// Closest points and line parameters of two 3D lines in signed fixed point,
// exact wide integer arithmetic with saturation of the results.
// ----------------------------------------------------------------------------
module line_line_closest_points #(
  parameter int COORD_WIDTH = llcp_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = llcp_pkg::FRAC_BITS
) (
  input  logic clk,
  input  logic rst,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [llcp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [llcp_pkg::CFG_DATA_W-1:0]      cfg_data,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] a_start_x,
  input  logic signed [COORD_WIDTH-1:0] a_start_y,
  input  logic signed [COORD_WIDTH-1:0] a_start_z,
  input  logic signed [COORD_WIDTH-1:0] a_end_x,
  input  logic signed [COORD_WIDTH-1:0] a_end_y,
  input  logic signed [COORD_WIDTH-1:0] a_end_z,
  input  logic signed [COORD_WIDTH-1:0] b_start_x,
  input  logic signed [COORD_WIDTH-1:0] b_start_y,
  input  logic signed [COORD_WIDTH-1:0] b_start_z,
  input  logic signed [COORD_WIDTH-1:0] b_end_x,
  input  logic signed [COORD_WIDTH-1:0] b_end_y,
  input  logic signed [COORD_WIDTH-1:0] b_end_z,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic signed [COORD_WIDTH-1:0] near_a_x,
  output logic signed [COORD_WIDTH-1:0] near_a_y,
  output logic signed [COORD_WIDTH-1:0] near_a_z,
  output logic signed [COORD_WIDTH-1:0] near_b_x,
  output logic signed [COORD_WIDTH-1:0] near_b_y,
  output logic signed [COORD_WIDTH-1:0] near_b_z,
  output logic signed [COORD_WIDTH-1:0] param_a,
  output logic signed [COORD_WIDTH-1:0] param_b,
  output logic                          overflow
);

  localparam int W     = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DIF   = W + 1;          // coordinate difference
  localparam int PRD   = 2 * DIF;        // product of differences
  localparam int DOT   = PRD + 2;        // dot product
  localparam int PR2   = 2 * DOT;        // product of dot products
  localparam int DEN   = PR2 + 1;        // denominator, numerator
  localparam int NA    = DEN + F;        // first dividend
  localparam int QA    = NA + 1;         // mua, unsaturated
  localparam int PQ    = QA + DOT;       // d4321 * mua
  localparam int NB    = PQ + 1;         // second dividend
  localparam int QB    = NB + 1;         // mub, unsaturated
  localparam int PA    = QA + DIF;       // mua * d21
  localparam int PB    = QB + DIF;       // mub * d43
  localparam int FMASK = (1 << F) - 1;

  localparam logic signed [PB-1:0] SMAX = {{(PB-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PB-1:0] SMIN = ~SMAX;

  typedef struct packed {
    logic [2:0][W-1:0]   a0;
    logic [2:0][W-1:0]   b0;
    logic [2:0][DIF-1:0] d21;
    logic [2:0][DIF-1:0] d43;
    logic                tiny;
  } geo_t;

  typedef struct packed {
    geo_t                   g;
    logic signed [DOT-1:0]  d1343;
    logic signed [DOT-1:0]  d4321;
    logic signed [DOT-1:0]  d4343;
  } dots_t;

  typedef struct packed {
    dots_t dt;
    logic  bad;
  } div_tag_t;

  typedef struct packed {
    geo_t                  g;
    logic signed [DOT-1:0] d1343;
    logic signed [DOT-1:0] d4343;
    logic signed [QA-1:0]  qa;
    logic                  bad;
  } mua_t;

  typedef struct packed {
    logic [2:0][W-1:0]    a0;
    logic [2:0][W-1:0]    b0;
    logic signed [QA-1:0] qa;
    logic signed [QB-1:0] qb;
    logic                 bad;
  } fin_t;

  logic adv;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [llcp_pkg::DIR_LIMIT_W-1:0] dir_lim;
  logic [llcp_pkg::DEN_LIMIT_W-1:0] den_lim;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_lim <= llcp_pkg::DIR_LIMIT_RESET;
      den_lim <= llcp_pkg::DEN_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        llcp_pkg::REG_DIRECTION_LIMIT:   dir_lim <= cfg_data[llcp_pkg::DIR_LIMIT_W-1:0];
        llcp_pkg::REG_DENOMINATOR_LIMIT: den_lim <= cfg_data[llcp_pkg::DEN_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: differences
  // --------------------------------------------------------------------------
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic signed [W-1:0] pa0 [3];
  logic signed [W-1:0] pa1 [3];
  logic signed [W-1:0] pb0 [3];
  logic signed [W-1:0] pb1 [3];

  always_comb begin
    pa0[0] = a_start_x; pa0[1] = a_start_y; pa0[2] = a_start_z;
    pa1[0] = a_end_x;   pa1[1] = a_end_y;   pa1[2] = a_end_z;
    pb0[0] = b_start_x; pb0[1] = b_start_y; pb0[2] = b_start_z;
    pb1[0] = b_end_x;   pb1[1] = b_end_y;   pb1[2] = b_end_z;
  end

  logic                  s1_vld;
  logic signed [W-1:0]   s1_a0  [3];
  logic signed [W-1:0]   s1_b0  [3];
  logic signed [DIF-1:0] s1_d21 [3];
  logic signed [DIF-1:0] s1_d43 [3];
  logic signed [DIF-1:0] s1_d13 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_a0[k]  <= pa0[k];
        s1_b0[k]  <= pb0[k];
        s1_d21[k] <= DIF'(pa1[k]) - DIF'(pa0[k]);
        s1_d43[k] <= DIF'(pb1[k]) - DIF'(pb0[k]);
        s1_d13[k] <= DIF'(pa0[k]) - DIF'(pb0[k]);
      end
    end
  end

  logic [DIF-1:0] abs21 [3];
  logic [DIF-1:0] abs43 [3];
  logic           tiny21;
  logic           tiny43;
  geo_t           s1_geo;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs21[k] = s1_d21[k][DIF-1] ? DIF'(-s1_d21[k]) : DIF'(s1_d21[k]);
      abs43[k] = s1_d43[k][DIF-1] ? DIF'(-s1_d43[k]) : DIF'(s1_d43[k]);
    end
    tiny21 = (abs21[0] < DIF'(dir_lim)) && (abs21[1] < DIF'(dir_lim)) &&
             (abs21[2] < DIF'(dir_lim));
    tiny43 = (abs43[0] < DIF'(dir_lim)) && (abs43[1] < DIF'(dir_lim)) &&
             (abs43[2] < DIF'(dir_lim));
    for (int k = 0; k < 3; k++) begin
      s1_geo.a0[k]  = s1_a0[k];
      s1_geo.b0[k]  = s1_b0[k];
      s1_geo.d21[k] = s1_d21[k];
      s1_geo.d43[k] = s1_d43[k];
    end
    s1_geo.tiny = tiny21 | tiny43;
  end

  // --------------------------------------------------------------------------
  // Dot product terms: d1343, d4321, d1321, d4343, d2121
  // --------------------------------------------------------------------------
  logic signed [DIF-1:0] dot_a [0:4][0:2];
  logic signed [DIF-1:0] dot_b [0:4][0:2];
  logic signed [PRD-1:0] dprod [0:4][0:2];
  logic                  dot_vld;
  logic [$bits(geo_t)-1:0] dot_tag;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dot_a[0][k] = s1_d13[k]; dot_b[0][k] = s1_d43[k];
      dot_a[1][k] = s1_d43[k]; dot_b[1][k] = s1_d21[k];
      dot_a[2][k] = s1_d13[k]; dot_b[2][k] = s1_d21[k];
      dot_a[3][k] = s1_d43[k]; dot_b[3][k] = s1_d43[k];
      dot_a[4][k] = s1_d21[k]; dot_b[4][k] = s1_d21[k];
    end
  end

  for (genvar j = 0; j < 5; j++) begin : g_dot
    for (genvar k = 0; k < 3; k++) begin : g_term
      if (j == 0 && k == 0) begin : g_tag
        llcp_mul #(.AW(DIF), .BW(DIF), .TW($bits(geo_t))) u_mul (
          .clk, .rst, .en(adv), .in_valid(s1_vld),
          .a(dot_a[j][k]), .b(dot_b[j][k]), .in_tag(s1_geo),
          .out_valid(dot_vld), .p(dprod[j][k]), .out_tag(dot_tag)
        );
      end else begin : g_plain
        llcp_mul #(.AW(DIF), .BW(DIF), .TW(1)) u_mul (
          .clk, .rst, .en(adv), .in_valid(s1_vld),
          .a(dot_a[j][k]), .b(dot_b[j][k]), .in_tag(1'b0),
          .out_valid(), .p(dprod[j][k]), .out_tag()
        );
      end
    end
  end

  logic                  d_vld;
  logic signed [DOT-1:0] d_dot [0:4];
  geo_t                  d_geo;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= dot_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 5; j++) begin
        d_dot[j] <= DOT'(dprod[j][0]) + DOT'(dprod[j][1]) + DOT'(dprod[j][2]);
      end
      d_geo <= geo_t'(dot_tag);
    end
  end

  // --------------------------------------------------------------------------
  // Denominator and numerator products
  // --------------------------------------------------------------------------
  dots_t                 d_dots;
  logic signed [PR2-1:0] m2p [0:3];
  logic                  m2_vld;
  logic [$bits(dots_t)-1:0] m2_tag;

  always_comb begin
    d_dots.g     = d_geo;
    d_dots.d1343 = d_dot[0];
    d_dots.d4321 = d_dot[1];
    d_dots.d4343 = d_dot[3];
  end

  llcp_mul #(.AW(DOT), .BW(DOT), .TW($bits(dots_t))) u_m2_0 (
    .clk, .rst, .en(adv), .in_valid(d_vld),
    .a(d_dot[4]), .b(d_dot[3]), .in_tag(d_dots),
    .out_valid(m2_vld), .p(m2p[0]), .out_tag(m2_tag)
  );

  llcp_mul #(.AW(DOT), .BW(DOT), .TW(1)) u_m2_1 (
    .clk, .rst, .en(adv), .in_valid(d_vld),
    .a(d_dot[1]), .b(d_dot[1]), .in_tag(1'b0),
    .out_valid(), .p(m2p[1]), .out_tag()
  );

  llcp_mul #(.AW(DOT), .BW(DOT), .TW(1)) u_m2_2 (
    .clk, .rst, .en(adv), .in_valid(d_vld),
    .a(d_dot[0]), .b(d_dot[1]), .in_tag(1'b0),
    .out_valid(), .p(m2p[2]), .out_tag()
  );

  llcp_mul #(.AW(DOT), .BW(DOT), .TW(1)) u_m2_3 (
    .clk, .rst, .en(adv), .in_valid(d_vld),
    .a(d_dot[2]), .b(d_dot[3]), .in_tag(1'b0),
    .out_valid(), .p(m2p[3]), .out_tag()
  );

  logic                  e_vld;
  logic signed [DEN-1:0] e_denom;
  logic signed [DEN-1:0] e_numer;
  dots_t                 e_dots;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_denom <= DEN'(m2p[0]) - DEN'(m2p[1]);
      e_numer <= DEN'(m2p[2]) - DEN'(m2p[3]);
      e_dots  <= dots_t'(m2_tag);
    end
  end

  // degenerate direction, parallel lines or zero denominators
  logic signed [DEN-1:0] lim_s;
  div_tag_t              e_tag;
  logic signed [NA-1:0]  e_dividend;

  always_comb begin
    lim_s      = DEN'($signed({1'b0, den_lim}));
    e_tag.dt   = e_dots;
    e_tag.bad  = e_dots.g.tiny || (e_denom == '0) || (e_dots.d4343 == '0) ||
                 ((e_denom < lim_s) && (e_denom > -lim_s));
    e_dividend = NA'(e_numer) <<< F;
  end

  // --------------------------------------------------------------------------
  // mua
  // --------------------------------------------------------------------------
  logic                    q1_vld;
  logic signed [QA-1:0]    q1_qa;
  logic [$bits(div_tag_t)-1:0] q1_tag;
  div_tag_t                q1_t;

  llcp_div #(.NW(NA), .VW(DEN), .TW($bits(div_tag_t))) u_div_a (
    .clk, .rst, .en(adv), .in_valid(e_vld),
    .n(e_dividend), .d(e_denom), .in_tag(e_tag),
    .out_valid(q1_vld), .q(q1_qa), .out_tag(q1_tag)
  );

  mua_t q1_mua;

  always_comb begin
    q1_t         = div_tag_t'(q1_tag);
    q1_mua.g     = q1_t.dt.g;
    q1_mua.d1343 = q1_t.dt.d1343;
    q1_mua.d4343 = q1_t.dt.d4343;
    q1_mua.qa    = q1_qa;
    q1_mua.bad   = q1_t.bad;
  end

  logic                  m3_vld;
  logic signed [PQ-1:0]  m3p;
  logic [$bits(mua_t)-1:0] m3_tag;
  mua_t                  m3_t;

  llcp_mul #(.AW(QA), .BW(DOT), .TW($bits(mua_t))) u_m3 (
    .clk, .rst, .en(adv), .in_valid(q1_vld),
    .a(q1_qa), .b(q1_t.dt.d4321), .in_tag(q1_mua),
    .out_valid(m3_vld), .p(m3p), .out_tag(m3_tag)
  );

  assign m3_t = mua_t'(m3_tag);

  logic                 g_vld;
  logic signed [NB-1:0] g_num;
  mua_t                 g_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (adv) begin
      g_vld <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_num <= (NB'(m3_t.d1343) <<< F) + NB'(m3p);
      g_t   <= m3_t;
    end
  end

  // --------------------------------------------------------------------------
  // mub
  // --------------------------------------------------------------------------
  logic                  q2_vld;
  logic signed [QB-1:0]  q2_qb;
  logic [$bits(mua_t)-1:0] q2_tag;
  mua_t                  q2_t;

  llcp_div #(.NW(NB), .VW(DOT), .TW($bits(mua_t))) u_div_b (
    .clk, .rst, .en(adv), .in_valid(g_vld),
    .n(g_num), .d(g_t.d4343), .in_tag(g_t),
    .out_valid(q2_vld), .q(q2_qb), .out_tag(q2_tag)
  );

  fin_t q2_fin;

  always_comb begin
    q2_t         = mua_t'(q2_tag);
    q2_fin.a0    = q2_t.g.a0;
    q2_fin.b0    = q2_t.g.b0;
    q2_fin.qa    = q2_t.qa;
    q2_fin.qb    = q2_qb;
    q2_fin.bad   = q2_t.bad;
  end

  // --------------------------------------------------------------------------
  // Offsets along each line
  // --------------------------------------------------------------------------
  logic signed [PA-1:0] m4a [3];
  logic signed [PB-1:0] m4b [3];
  logic                 m4_vld;
  logic [$bits(fin_t)-1:0] m4_tag;

  for (genvar k = 0; k < 3; k++) begin : g_near
    llcp_mul #(.AW(QA), .BW(DIF), .TW(1)) u_ma (
      .clk, .rst, .en(adv), .in_valid(q2_vld),
      .a(q2_t.qa), .b($signed(q2_t.g.d21[k])), .in_tag(1'b0),
      .out_valid(), .p(m4a[k]), .out_tag()
    );
    if (k == 0) begin : g_tag
      llcp_mul #(.AW(QB), .BW(DIF), .TW($bits(fin_t))) u_mb (
        .clk, .rst, .en(adv), .in_valid(q2_vld),
        .a(q2_qb), .b($signed(q2_t.g.d43[k])), .in_tag(q2_fin),
        .out_valid(m4_vld), .p(m4b[k]), .out_tag(m4_tag)
      );
    end else begin : g_plain
      llcp_mul #(.AW(QB), .BW(DIF), .TW(1)) u_mb (
        .clk, .rst, .en(adv), .in_valid(q2_vld),
        .a(q2_qb), .b($signed(q2_t.g.d43[k])), .in_tag(1'b0),
        .out_valid(), .p(m4b[k]), .out_tag()
      );
    end
  end

  // truncate toward zero on the fraction shift
  logic signed [PA-1:0] ta [3];
  logic signed [PB-1:0] tb [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ta[k] = (m4a[k] + (m4a[k][PA-1] ? PA'(FMASK) : PA'(0))) >>> F;
      tb[k] = (m4b[k] + (m4b[k][PB-1] ? PB'(FMASK) : PB'(0))) >>> F;
    end
  end

  logic                 h1_vld;
  logic signed [PA-1:0] h1_ta [3];
  logic signed [PB-1:0] h1_tb [3];
  fin_t                 h1_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_vld <= 1'b0;
    end else if (adv) begin
      h1_vld <= m4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        h1_ta[k] <= ta[k];
        h1_tb[k] <= tb[k];
      end
      h1_t <= fin_t'(m4_tag);
    end
  end

  // --------------------------------------------------------------------------
  // Saturate and hold the result
  // --------------------------------------------------------------------------
  function automatic logic [W:0] sat_w(input logic signed [PB-1:0] v);
    logic [W:0] r;
    if (v > SMAX) begin
      r = {1'b1, SMAX[W-1:0]};
    end else if (v < SMIN) begin
      r = {1'b1, SMIN[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  logic [W:0] sa [3];
  logic [W:0] sb [3];
  logic [W:0] sqa;
  logic [W:0] sqb;
  logic       any_ovf;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sa[k] = sat_w(PB'(PA'($signed(h1_t.a0[k])) + h1_ta[k]));
      sb[k] = sat_w(PB'($signed(h1_t.b0[k])) + h1_tb[k]);
    end
    sqa     = sat_w(PB'(h1_t.qa));
    sqb     = sat_w(PB'(h1_t.qb));
    any_ovf = sa[0][W] | sa[1][W] | sa[2][W] | sb[0][W] | sb[1][W] | sb[2][W] |
              sqa[W] | sqb[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= h1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found    <= !h1_t.bad;
      near_a_x <= h1_t.bad ? '0 : $signed(sa[0][W-1:0]);
      near_a_y <= h1_t.bad ? '0 : $signed(sa[1][W-1:0]);
      near_a_z <= h1_t.bad ? '0 : $signed(sa[2][W-1:0]);
      near_b_x <= h1_t.bad ? '0 : $signed(sb[0][W-1:0]);
      near_b_y <= h1_t.bad ? '0 : $signed(sb[1][W-1:0]);
      near_b_z <= h1_t.bad ? '0 : $signed(sb[2][W-1:0]);
      param_a  <= h1_t.bad ? '0 : $signed(sqa[W-1:0]);
      param_b  <= h1_t.bad ? '0 : $signed(sqb[W-1:0]);
      overflow <= !h1_t.bad && any_ovf;
    end
  end

`ifndef SYNTHESIS
  a_nofind_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> !overflow && param_a == '0 && param_b == '0 &&
      near_a_x == '0 && near_b_x == '0)
    else $error("result without solution carries nonzero fields");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_vld && dir_lim == llcp_pkg::DIR_LIMIT_RESET &&
      den_lim == llcp_pkg::DEN_LIMIT_RESET)
    else $error("reset did not clear pipeline or load limits");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_vld && !adv |=> s1_vld && $stable(s1_d21[0]))
    else $error("first stage lost its item under stall");

  a_cfg_unknown: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_index != llcp_pkg::REG_DIRECTION_LIMIT &&
      cfg_index != llcp_pkg::REG_DENOMINATOR_LIMIT |=> $stable(dir_lim) && $stable(den_lim))
    else $error("write to unknown register changed a limit");
`endif

endmodule
`default_nettype wire
